// File: rtl/core/bgpe_pkg.sv
// shared types and constants of the bitmap glyph pixel expander
// no dependencies; imported by every module of the block
package bgpe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 3'd4;

  localparam logic [7:0] WIDTH_RESET  = 8'd8;
  localparam logic [9:0] HEIGHT_RESET = 10'd8;
  localparam logic [7:0] TOP_BIT      = 8'h80;

  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [7:0]  width_px;
    logic [9:0]  height_rows;
    logic [15:0] draw_color;
  } cfg_t;

  // one nonempty byte with its row position resolved
  typedef struct packed {
    logic [7:0]  bits;
    logic [9:0]  x_base;
    logic [9:0]  y;
    logic [15:0] color;
  } glyph_op_t;

  // mask that keeps the low coordinate bits, capped at the 10 bit field
  function automatic logic [9:0] coord_mask(input int coord_bits);
    logic [9:0] m;
    m = '0;
    for (int i = 0; i < 10; i++) begin
      if (i < coord_bits) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// File: rtl/core/bgpe_front.sv
// front end: takes bitmap bytes, tracks row and byte position, queues nonempty bytes
// depends on bgpe_pkg
module bgpe_front #(
  parameter int COORD_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  bgpe_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        bitmap_byte,
  input  logic              glyph_start,
  input  logic              q_full,
  output logic              q_push,
  output bgpe_pkg::glyph_op_t q_op
);
  import bgpe_pkg::*;

  localparam logic [9:0] MASK = coord_mask(COORD_BITS);

  logic [9:0] row_index;
  logic [4:0] byte_in_row;
  logic [9:0] row_index_next;
  logic [4:0] byte_in_row_next;

  logic [9:0] row_eff;
  logic [4:0] byte_eff;
  logic [5:0] bytes_per_row;
  logic [4:0] byte_inc;
  logic       keep;
  logic       accept;

  assign in_ready      = !q_full;
  assign accept        = in_valid && in_ready;
  assign row_eff       = glyph_start ? '0 : row_index;
  assign byte_eff      = glyph_start ? '0 : byte_in_row;
  assign bytes_per_row = {1'b0, cfg.width_px[7:3]} + {5'd0, |cfg.width_px[2:0]};
  assign keep          = (bytes_per_row != '0) && (row_eff < cfg.height_rows);
  assign byte_inc      = byte_eff + 5'd1;

  always_comb begin
    row_index_next   = row_index;
    byte_in_row_next = byte_in_row;
    if (accept) begin
      row_index_next   = row_eff;
      byte_in_row_next = byte_eff;
      if (keep) begin
        if (({1'b0, byte_inc} >= bytes_per_row) || (byte_inc == '0)) begin
          byte_in_row_next = '0;
          row_index_next   = row_eff + 10'd1;
        end else begin
          byte_in_row_next = byte_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      byte_in_row <= '0;
    end else begin
      row_index   <= row_index_next;
      byte_in_row <= byte_in_row_next;
    end
  end

  assign q_push       = accept && keep && (bitmap_byte != '0);
  assign q_op.bits    = bitmap_byte;
  assign q_op.x_base  = cfg.origin_x + {2'b00, byte_eff, 3'b000};
  assign q_op.y       = (cfg.origin_y + row_eff) & MASK;
  assign q_op.color   = cfg.draw_color;

endmodule

// File: rtl/core/bgpe_queue.sv
// short queue of classified bytes between front and back end
// depends on bgpe_pkg
module bgpe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bgpe_pkg::glyph_op_t push_op,
  input  logic                pop,
  output bgpe_pkg::glyph_op_t head_op,
  output logic                full,
  output logic                empty
);
  import bgpe_pkg::*;

  glyph_op_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/bgpe_back.sv
// back end: scans each queued byte msb first and emits one pixel per cycle
// while the output is not stalled; depends on bgpe_pkg
module bgpe_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  bgpe_pkg::glyph_op_t head_op,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          pixel_x,
  output logic [9:0]          pixel_y,
  output logic [15:0]         pixel_color,
  output logic                run_last
);
  import bgpe_pkg::*;

  localparam logic [9:0] MASK = coord_mask(COORD_BITS);

  glyph_op_t  work;
  logic       work_valid;
  logic [2:0] k;
  logic [7:0] rest;
  logic       last;
  logic       emit;

  // leading set bit, counted from the left
  always_comb begin
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (work.bits[i]) k = 3'(7 - i);
    end
  end

  assign rest  = work.bits & ~(TOP_BIT >> k);
  assign last  = (rest == '0);
  assign emit  = work_valid && (!out_valid || out_ready);
  assign q_pop = !q_empty && (!work_valid || (emit && last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= head_op;
    end else if (emit) begin
      work.bits <= rest;
    end
    if (emit) begin
      pixel_x     <= (work.x_base + {7'd0, k}) & MASK;
      pixel_y     <= work.y;
      pixel_color <= work.color;
      run_last    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (q_pop) work_valid <= 1'b1;
      else if (emit && last) work_valid <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/bitmap_glyph_pixel_expander.sv
// top level of the bitmap glyph pixel expander: configuration registers and the
// front end, queue and back end; depends on bgpe_pkg, bgpe_front, bgpe_queue, bgpe_back
//
// Each input transfer carries one 1 bit per pixel bitmap byte; every set bit becomes
// one pixel transfer, leftmost bit first, with tlast on the last pixel of that byte.
// Bytes with no set bits and bytes past the last row produce no output. The front
// end takes one byte per cycle while the queue is not full; the back end emits one
// pixel per cycle while the output is not stalled, one pixel for each set bit of a
// byte. A two entry queue lets the input keep moving while the output is stalled.
// The first pixel of a byte passes from the queue through the back end's work
// register into the output register before it is presented.
module bitmap_glyph_pixel_expander #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bgpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgpe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // bitmap_byte
  input  logic                                s_tuser,   // glyph_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,   // pixel_x, pixel_y, pixel_color, pad
  output logic                                m_tlast    // run_last
);
  import bgpe_pkg::*;

  cfg_t      cfg;
  glyph_op_t push_op;
  glyph_op_t head_op;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] pixel_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.width_px    <= WIDTH_RESET;
      cfg.height_rows <= HEIGHT_RESET;
      cfg.draw_color  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:    cfg.origin_x    <= cfg_data[9:0];
        REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data[9:0];
        REG_WIDTH_PX:    cfg.width_px    <= cfg_data[7:0];
        REG_HEIGHT_ROWS: cfg.height_rows <= cfg_data[9:0];
        REG_DRAW_COLOR:  cfg.draw_color  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bgpe_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .bitmap_byte(s_tdata),
    .glyph_start(s_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  bgpe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .push_op(push_op),
    .pop    (q_pop),
    .head_op(head_op),
    .full   (q_full),
    .empty  (q_empty)
  );

  bgpe_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .run_last   (m_tlast)
  );

  assign m_tdata = {4'd0, pixel_color, pixel_y, pixel_x};

endmodule

// File: tb/tb_bitmap_glyph_pixel_expander.sv
// self-checking testbench of bitmap_glyph_pixel_expander: bitmap bytes in, pixels out
// depends on bgpe_pkg and the block; a scoreboard class predicts every pixel from the register state
module tb_bitmap_glyph_pixel_expander;
  import bgpe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 260;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  class glyph_scoreboard;
    logic [9:0]  org_x;
    logic [9:0]  org_y;
    logic [7:0]  width;
    logic [9:0]  height;
    logic [15:0] color;
    logic [9:0]  row;
    logic [4:0]  col_byte;
    pixel_t      want_q[$];
    int          errors;

    function new();
      org_x    = '0;
      org_y    = '0;
      width    = WIDTH_RESET;
      height   = HEIGHT_RESET;
      color    = '0;
      row      = '0;
      col_byte = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ORIGIN_X:    org_x = val[9:0];
        REG_ORIGIN_Y:    org_y = val[9:0];
        REG_WIDTH_PX:    width = val[7:0];
        REG_HEIGHT_ROWS: height = val[9:0];
        REG_DRAW_COLOR:  color = val;
        default: ;
      endcase
    endfunction

    // returns 1 when the byte lands inside the glyph
    function bit note_byte(logic [7:0] bits, logic start);
      int     per_row;
      int     lowest;
      pixel_t p;
      if (start) begin
        row      = '0;
        col_byte = '0;
      end
      per_row = (int'(width) + 7) / 8;
      if (per_row == 0 || row >= height) return 1'b0;
      lowest = -1;
      for (int k = 0; k < 8; k++) begin
        if ((bits & (TOP_BIT >> k)) != 0) lowest = k;
      end
      for (int k = 0; k < 8; k++) begin
        if ((bits & (TOP_BIT >> k)) != 0) begin
          p.x     = org_x + 10'({col_byte, 3'b000}) + 10'(k);
          p.y     = org_y + row;
          p.color = color;
          p.last  = (k == lowest);
          want_q.push_back(p);
        end
      end
      col_byte = col_byte + 5'd1;
      if (col_byte >= per_row || col_byte == 0) begin
        col_byte = '0;
        row      = row + 10'd1;
      end
      return 1'b1;
    endfunction

    function void check_pixel(logic [39:0] data, logic last);
      pixel_t want;
      pixel_t got;
      got.x     = data[9:0];
      got.y     = data[19:10];
      got.color = data[35:20];
      got.last  = last;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel transfer: x=%0d y=%0d color=%h last=%b",
                   got.x, got.y, got.color, got.last);
        return;
      end
      want = want_q.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                   want.x, want.y, want.color, want.last,
                   got.x, got.y, got.color, got.last);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // bitmap_byte
  logic                  s_tuser = 1'b0; // glyph_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;        // pixel_x, pixel_y, pixel_color, pad
  logic                  m_tlast;        // run_last

  glyph_scoreboard sb = new();
  bit steady = 1'b0;
  bit long_hold = 1'b0;
  int cycle_count = 0;
  int used_bytes = 0;

  bitmap_glyph_pixel_expander uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
  end

  // pixel sink with random stalls and one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_byte(input logic [7:0] bits, input logic start);
    while (!steady && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= bits;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    if (sb.note_byte(bits, start)) used_bytes++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input int ox, input int oy, input int w, input int h,
                            input int c);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  idx[5];
    vals = '{CFG_DATA_W'(ox), CFG_DATA_W'(oy), CFG_DATA_W'(w), CFG_DATA_W'(h),
             CFG_DATA_W'(c)};
    idx  = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_WIDTH_PX, REG_HEIGHT_ROWS, REG_DRAW_COLOR};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_bits();
    case ($urandom_range(7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      3:       return TOP_BIT >> $urandom_range(7);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_run(input int count, input bit with_start);
    for (int i = 0; i < count; i++) send_byte(random_bits(), with_start && i == 0);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1023;
      2:       return 1020 + $urandom_range(3);
      default: return $urandom_range(1023);
    endcase
  endfunction

  initial begin
    int ox, oy, w, h, per_row, glyphs, phase, n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset registers, start flag only on the last byte: row and column from reset
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_idle();

    // coordinate wrap at the far corner with the widest and tallest glyph
    set_config(1020, 1023, 255, 1023, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_idle();

    // zero width, then zero height: every byte dropped
    set_config(0, 0, 0, 5, 16'h1234);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h0F, 1'b0);
    wait_idle();
    set_config(5, 7, 9, 0, 16'h5A5A);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_idle();

    // one pixel wide: set padding bits are still drawn
    set_config(100, 200, 1, 2, 16'h0000);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_idle();

    // long output hold while dense bytes keep coming
    set_config(300, 400, 16, 6, 16'hC3C3);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_byte(i == 5 ? 8'h00 : 8'hFF, i == 0);
    wait_idle();

    phase = 0;
    while (used_bytes < RANDOM_BYTES - 30) begin
      ox = pick_coord();
      oy = pick_coord();
      case ($urandom_range(19))
        0:       w = 255;
        1:       w = 0;
        default: w = $urandom_range(1, 24);
      endcase
      case ($urandom_range(19))
        0:       h = 1023;
        1:       h = 0;
        default: h = $urandom_range(1, 4);
      endcase
      if (w == 255) h = 1;
      steady = (phase == 4);
      set_config(ox, oy, w, h, $urandom_range(65535));
      per_row = (w + 7) / 8;
      glyphs = $urandom_range(1, 3);
      for (int g = 0; g < glyphs; g++) begin
        n = (h == 1023) ? $urandom_range(1, 10) : per_row * h;
        if (n == 0) n = 2;
        case ($urandom_range(9))
          0: send_run($urandom_range(1, n), 1'b1);
          1: send_run(n, !(g == 0 && phase % 5 == 2));
          2: begin
            send_run(n, 1'b1);
            send_run($urandom_range(1, 3), 1'b0);
          end
          default: send_run(n, !(g == 0 && phase % 5 == 2));
        endcase
      end
      wait_idle();
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
